// File: sv/tte_pkg.sv
// Shared types, constants and lookup functions for the timestamp text to epoch converter.
package tte_pkg;

  localparam int TTE_QUEUE_DEPTH = 4;

  localparam int FLD_COUNT  = 8;
  localparam int POS_W      = 6;
  localparam int YEAR_W     = 14;
  localparam int NARROW_W   = 7;
  localparam int SUB_W      = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 1;
  localparam int HMS_W      = 19;
  localparam int YD_W       = 23;
  localparam int MD_W       = 12;
  localparam int DAYS_W     = 24;
  localparam int SEC_W      = 40;
  localparam int MS_W       = 50;
  localparam int EPOCH_W    = 60;

  localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT   = 2'd1;

  localparam logic [2:0] FLD_YEAR   = 3'd0;
  localparam logic [2:0] FLD_MONTH  = 3'd1;
  localparam logic [2:0] FLD_DAY    = 3'd2;
  localparam logic [2:0] FLD_HOUR   = 3'd3;
  localparam logic [2:0] FLD_MINUTE = 3'd4;
  localparam logic [2:0] FLD_SECOND = 3'd5;
  localparam logic [2:0] FLD_MILLI  = 3'd6;
  localparam logic [2:0] FLD_MICRO  = 3'd7;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  localparam logic [YEAR_W-1:0] EPOCH_YEAR         = 14'd1970;
  localparam logic [10:0]       RECIP25            = 11'd1311;
  localparam logic [8:0]        LEAPS_BEFORE_EPOCH = 9'd477;
  localparam logic [16:0]       DAY_SECONDS        = 17'd86400;
  localparam logic [SUB_W-1:0]  MICRO_PER_MILLI    = 10'd1000;

  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [NARROW_W-1:0] month;
    logic [NARROW_W-1:0] day;
    logic [NARROW_W-1:0] hour;
    logic [NARROW_W-1:0] minute;
    logic [NARROW_W-1:0] second;
    logic [SUB_W-1:0]    milli;
    logic [SUB_W-1:0]    micro;
  } tte_fields_t;

  typedef struct packed {
    tte_fields_t fld;
    logic        short_input;
  } tte_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } tte_q_stat_t;

  typedef struct packed {
    logic [3:0] stage_vld;
  } tte_back_stat_t;

  // first character position of a field
  function automatic logic [POS_W-1:0] fld_start(input logic lay, input logic [2:0] idx);
    logic [POS_W-1:0] s;
    unique case (idx)
      FLD_YEAR:   s = 6'd0;
      FLD_MONTH:  s = lay ? 6'd4  : 6'd5;
      FLD_DAY:    s = lay ? 6'd6  : 6'd8;
      FLD_HOUR:   s = lay ? 6'd9  : 6'd11;
      FLD_MINUTE: s = lay ? 6'd11 : 6'd14;
      FLD_SECOND: s = lay ? 6'd13 : 6'd17;
      FLD_MILLI:  s = lay ? 6'd16 : 6'd20;
      FLD_MICRO:  s = lay ? 6'd19 : 6'd23;
    endcase
    return s;
  endfunction

  // one past the last character position of a field
  function automatic logic [POS_W-1:0] fld_end(input logic lay, input logic [2:0] idx);
    logic [POS_W-1:0] e;
    unique case (idx)
      FLD_YEAR:   e = 6'd4;
      FLD_MONTH:  e = lay ? 6'd6  : 6'd7;
      FLD_DAY:    e = lay ? 6'd8  : 6'd10;
      FLD_HOUR:   e = lay ? 6'd11 : 6'd13;
      FLD_MINUTE: e = lay ? 6'd13 : 6'd16;
      FLD_SECOND: e = lay ? 6'd15 : 6'd19;
      FLD_MILLI:  e = lay ? 6'd19 : 6'd23;
      FLD_MICRO:  e = lay ? 6'd22 : 6'd26;
    endcase
    return e;
  endfunction

  // days in the year before the month at index (month - 1), non-leap
  function automatic logic [MD_W-1:0] days_before_month(input logic [3:0] idx);
    logic [MD_W-1:0] d;
    unique case (idx)
      4'd0:    d = 12'd0;
      4'd1:    d = 12'd31;
      4'd2:    d = 12'd59;
      4'd3:    d = 12'd90;
      4'd4:    d = 12'd120;
      4'd5:    d = 12'd151;
      4'd6:    d = 12'd181;
      4'd7:    d = 12'd212;
      4'd8:    d = 12'd243;
      4'd9:    d = 12'd273;
      4'd10:   d = 12'd304;
      4'd11:   d = 12'd334;
      4'd12:   d = 12'd365;
      default: d = 12'd0;
    endcase
    return d;
  endfunction

  // v * 10 + d, wrapped to the accumulator width
  function automatic logic [YEAR_W-1:0] push_digit(input logic [YEAR_W-1:0] v,
                                                   input logic [3:0] d);
    return (v << 3) + (v << 1) + {10'd0, d};
  endfunction

endpackage

// File: sv/tte_if.sv
// Valid/ready channel interfaces for characters in and epoch results out.
interface tte_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       is_final;

  modport source (output valid, output text_char, output is_final, input ready);
  modport sink (input valid, input text_char, input is_final, output ready);
endinterface

interface tte_out_if;
  logic               valid;
  logic               ready;
  logic signed [59:0] epoch_count;
  logic               short_input;

  modport source (output valid, output epoch_count, output short_input, input ready);
  modport sink (input valid, input epoch_count, input short_input, output ready);
endinterface

// File: sv/timestamp_text_to_epoch.sv
// Top level: configuration registers, parser, queue and epoch pipeline.
//
// Accepts one timestamp character per clock on in_chan and, for the character marked
// final, delivers one word on out_chan: the count since 1970-01-01 in microseconds or
// in milliseconds truncated toward zero (cfg register 1), with fields placed by the
// extended or basic layout (cfg register 0), and short_input set with a zero count
// when the text ends before the microsecond field. The parser updates its field
// accumulators per character; a final character leaves through a QUEUE_DEPTH-entry
// queue into a pipelined back end (year-day and leap terms, day-to-second multiply,
// two times-1000 steps, output register), and results follow at up to one per cycle.
// in_chan.ready falls only while the queue is full because out_chan is being held
// off.
module timestamp_text_to_epoch #(
  parameter int QUEUE_DEPTH = tte_pkg::TTE_QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  tte_in_if.sink                          in_chan,
  tte_out_if.source                       out_chan,
  input  logic                            cfg_we,
  input  logic [tte_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tte_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import tte_pkg::*;

  logic           layout_mode_r, layout_mode_nxt;
  logic           unit_mode_r, unit_mode_nxt;
  logic           q_push, q_pop;
  tte_entry_t     q_wdata, q_rdata;
  tte_q_stat_t    q_stat;
  tte_back_stat_t back_stat;

  always_comb begin
    layout_mode_nxt = layout_mode_r;
    unit_mode_nxt   = unit_mode_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_LAYOUT: layout_mode_nxt = cfg_wdata[0];
        CFG_UNIT:   unit_mode_nxt   = cfg_wdata[0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layout_mode_r <= 1'b0;
      unit_mode_r   <= 1'b0;
    end else begin
      layout_mode_r <= layout_mode_nxt;
      unit_mode_r   <= unit_mode_nxt;
    end
  end

  tte_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .layout_mode (layout_mode_r),
    .in_chan     (in_chan),
    .q_stat      (q_stat),
    .q_push      (q_push),
    .q_wdata     (q_wdata)
  );

  tte_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  tte_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .unit_mode (unit_mode_r),
    .q_stat    (q_stat),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_chan  (out_chan),
    .stat      (back_stat)
  );

`ifndef SYNTHESIS
  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.short_input |-> out_chan.epoch_count == '0)
    else $error("short text result carries a non-zero count");

  a_idle_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready && in_chan.is_final && q_stat.empty
    && (back_stat.stage_vld == '0) && !out_chan.valid |-> ##6 out_chan.valid)
    else $error("final word through an idle back end missed its result slot");

  a_ms_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && unit_mode_r |->
    (out_chan.epoch_count[59:49] == '0) || (out_chan.epoch_count[59:49] == '1))
    else $error("millisecond result not sign-extended");
`endif

endmodule

// File: sv/tte_front.sv
// Character parser: tracks position and accumulates the decimal fields of one timestamp.
module tte_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 layout_mode,
  tte_in_if.sink               in_chan,
  input  tte_pkg::tte_q_stat_t q_stat,
  output logic                 q_push,
  output tte_pkg::tte_entry_t  q_wdata
);
  import tte_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  tte_fields_t      fld_r, fld_nxt, fld_upd;
  logic             stopped_r, stopped_nxt, stopped_upd;
  logic             accept;
  logic             act_vld;
  logic [2:0]       act_idx;
  logic             at_start;
  logic             is_digit;
  logic [3:0]       dval;
  logic             stop_eff;

  assign in_chan.ready = ~q_stat.full;
  assign accept        = in_chan.valid & in_chan.ready;

  always_comb begin
    act_vld  = 1'b0;
    act_idx  = FLD_YEAR;
    at_start = 1'b0;
    for (int f = 0; f < FLD_COUNT; f++) begin
      if ((pos_r >= fld_start(layout_mode, 3'(f))) && (pos_r < fld_end(layout_mode, 3'(f)))) begin
        act_vld  = 1'b1;
        act_idx  = 3'(f);
        at_start = (pos_r == fld_start(layout_mode, 3'(f)));
      end
    end

    is_digit = (in_chan.text_char >= CHAR_ZERO) && (in_chan.text_char <= CHAR_NINE);
    dval     = 4'(in_chan.text_char - CHAR_ZERO);
    stop_eff = at_start ? 1'b0 : stopped_r;

    fld_upd     = fld_r;
    stopped_upd = stopped_r;
    if (act_vld) begin
      // a non-digit closes the field until the next field starts
      stopped_upd = stop_eff | ~is_digit;
      if (is_digit && !stop_eff) begin
        unique case (act_idx)
          FLD_YEAR:   fld_upd.year   = push_digit(fld_r.year, dval);
          FLD_MONTH:  fld_upd.month  = NARROW_W'(push_digit({7'd0, fld_r.month}, dval));
          FLD_DAY:    fld_upd.day    = NARROW_W'(push_digit({7'd0, fld_r.day}, dval));
          FLD_HOUR:   fld_upd.hour   = NARROW_W'(push_digit({7'd0, fld_r.hour}, dval));
          FLD_MINUTE: fld_upd.minute = NARROW_W'(push_digit({7'd0, fld_r.minute}, dval));
          FLD_SECOND: fld_upd.second = NARROW_W'(push_digit({7'd0, fld_r.second}, dval));
          FLD_MILLI:  fld_upd.milli  = SUB_W'(push_digit({4'd0, fld_r.milli}, dval));
          FLD_MICRO:  fld_upd.micro  = SUB_W'(push_digit({4'd0, fld_r.micro}, dval));
        endcase
      end
    end

    if (in_chan.is_final) begin
      pos_nxt     = '0;
      fld_nxt     = '0;
      stopped_nxt = 1'b0;
    end else begin
      pos_nxt     = (pos_r == {POS_W{1'b1}}) ? pos_r : pos_r + 6'd1;
      fld_nxt     = fld_upd;
      stopped_nxt = stopped_upd;
    end
  end

  assign q_push              = accept & in_chan.is_final;
  assign q_wdata.fld         = fld_upd;
  assign q_wdata.short_input = ({1'b0, pos_r} + 7'd1) < {1'b0, fld_start(layout_mode, FLD_MICRO)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      fld_r     <= '0;
      stopped_r <= 1'b0;
    end else if (accept) begin
      pos_r     <= pos_nxt;
      fld_r     <= fld_nxt;
      stopped_r <= stopped_nxt;
    end
  end

endmodule

// File: sv/tte_queue.sv
// Short queue of parsed timestamps between the parser and the epoch pipeline.
module tte_queue #(
  parameter int DEPTH = tte_pkg::TTE_QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  tte_pkg::tte_entry_t  wdata,
  input  logic                 pop,
  output tte_pkg::tte_entry_t  rdata,
  output tte_pkg::tte_q_stat_t stat
);
  import tte_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tte_entry_t       ent_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push_ok, pop_ok;

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign push_ok    = push & ~stat.full;
  assign pop_ok     = pop & ~stat.empty;
  assign rdata      = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    unique case ({push_ok, pop_ok})
      2'b10:   cnt_nxt = cnt_r + CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      ent_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// File: sv/tte_back.sv
// Epoch pipeline: day count, seconds, milliseconds and microseconds, with an output register.
module tte_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    unit_mode,
  input  tte_pkg::tte_q_stat_t    q_stat,
  input  tte_pkg::tte_entry_t     q_rdata,
  output logic                    q_pop,
  tte_out_if.source               out_chan,
  output tte_pkg::tte_back_stat_t stat
);
  import tte_pkg::*;

  logic advance;

  // stage 1: divisions by 100 through a reciprocal, time of day in seconds
  logic                s1_vld_r;
  logic                s1_short_r;
  logic [YEAR_W-1:0]   s1_year_r;
  logic [NARROW_W-1:0] s1_month_r, s1_day_r;
  logic [SUB_W-1:0]    s1_milli_r, s1_micro_r;
  logic [11:0]         s1_qy_r, s1_qp_r;
  logic [7:0]          s1_cy_r, s1_cy_nxt, s1_cp_r, s1_cp_nxt;
  logic [HMS_W-1:0]    s1_hms_r, s1_hms_nxt;
  logic [YEAR_W-1:0]   year_m1;
  logic [22:0]         prod_y, prod_p;

  // stage 2: day count
  logic                s2_vld_r;
  logic                s2_short_r;
  logic [DAYS_W-1:0]   s2_days_r, s2_days_nxt;
  logic [HMS_W-1:0]    s2_hms_r;
  logic [SUB_W-1:0]    s2_milli_r, s2_micro_r;
  logic [11:0]         c25;
  logic                leap;
  logic [YEAR_W-1:0]   year_off;
  logic [YD_W-1:0]     yd;
  logic [MD_W-1:0]     md;

  // stage 3: seconds
  logic                s3_vld_r;
  logic                s3_short_r;
  logic [SEC_W-1:0]    s3_sec_r, s3_sec_nxt;
  logic [SUB_W-1:0]    s3_milli_r, s3_micro_r;

  // stage 4: milliseconds
  logic                s4_vld_r;
  logic                s4_short_r;
  logic [MS_W-1:0]     s4_ms_r, s4_ms_nxt;
  logic [SUB_W-1:0]    s4_micro_r;
  logic [MS_W-1:0]     sec_ext;

  // output
  logic                out_vld_r;
  logic [EPOCH_W-1:0]  out_epoch_r, out_epoch_nxt;
  logic                out_short_r;
  logic [EPOCH_W-1:0]  ms_ext, us_val;
  logic [MS_W-1:0]     ms_adj;
  logic [1:0]          ms_inc;

  assign advance = ~out_vld_r | out_chan.ready;
  assign q_pop   = advance & ~q_stat.empty;

  assign out_chan.valid       = out_vld_r;
  assign out_chan.epoch_count = out_epoch_r;
  assign out_chan.short_input = out_short_r;
  assign stat.stage_vld       = {s4_vld_r, s3_vld_r, s2_vld_r, s1_vld_r};

  always_comb begin
    year_m1    = q_rdata.fld.year - 14'd1;
    // floor(q / 25) = (q * 1311) >> 15 for every 12-bit q
    prod_y     = 23'(q_rdata.fld.year[13:2]) * 23'(RECIP25);
    prod_p     = 23'(year_m1[13:2]) * 23'(RECIP25);
    s1_cy_nxt  = prod_y[22:15];
    s1_cp_nxt  = prod_p[22:15];
    s1_hms_nxt = HMS_W'(q_rdata.fld.hour) * HMS_W'(3600)
               + HMS_W'(q_rdata.fld.minute) * HMS_W'(60)
               + HMS_W'(q_rdata.fld.second);
  end

  always_comb begin
    c25  = {s1_cy_r, 4'd0} + {1'b0, s1_cy_r, 3'd0} + {4'd0, s1_cy_r};
    // divisible by four, and either not by 100 or also by 400
    leap = (s1_year_r[1:0] == 2'd0) && ((s1_qy_r != c25) || (s1_cy_r[1:0] == 2'd0));

    year_off = s1_year_r - EPOCH_YEAR;
    if (s1_year_r > EPOCH_YEAR) begin
      yd = YD_W'(year_off) * YD_W'(365) + YD_W'(s1_qp_r) - YD_W'(s1_cp_r)
         + YD_W'(s1_cp_r[7:2]) - YD_W'(LEAPS_BEFORE_EPOCH);
    end else begin
      yd = '0;
    end

    priority if (s1_month_r < 7'd2) begin
      md = '0;
    end else if (s1_month_r <= 7'd13) begin
      md = days_before_month(4'(s1_month_r - 7'd1));
    end else begin
      // every month after December counts 31 days
      md = 12'd365 + MD_W'(s1_month_r - 7'd13) * 12'd31;
    end
    if ((s1_month_r > 7'd2) && leap) begin
      md = md + 12'd1;
    end

    s2_days_nxt = DAYS_W'(yd) + DAYS_W'(md) + DAYS_W'(s1_day_r) - DAYS_W'(1);
  end

  always_comb begin
    s3_sec_nxt = {{(SEC_W - DAYS_W){s2_days_r[DAYS_W-1]}}, s2_days_r} * SEC_W'(DAY_SECONDS)
               + SEC_W'(s2_hms_r);
  end

  always_comb begin
    sec_ext   = {{(MS_W - SEC_W){s3_sec_r[SEC_W-1]}}, s3_sec_r};
    s4_ms_nxt = (sec_ext << 10) - (sec_ext << 4) - (sec_ext << 3) + MS_W'(s3_milli_r);
  end

  always_comb begin
    ms_ext = {{(EPOCH_W - MS_W){s4_ms_r[MS_W-1]}}, s4_ms_r};
    us_val = (ms_ext << 10) - (ms_ext << 4) - (ms_ext << 3) + EPOCH_W'(s4_micro_r);

    // truncate toward zero: floor for a non-negative count, ceiling otherwise
    priority if (!s4_ms_r[MS_W-1]) begin
      ms_inc = (s4_micro_r >= MICRO_PER_MILLI) ? 2'd1 : 2'd0;
    end else if (&s4_ms_r) begin
      ms_inc = (s4_micro_r != '0) ? 2'd1 : 2'd0;
    end else if (s4_micro_r == '0) begin
      ms_inc = 2'd0;
    end else if (s4_micro_r <= MICRO_PER_MILLI) begin
      ms_inc = 2'd1;
    end else begin
      ms_inc = 2'd2;
    end
    ms_adj = s4_ms_r + MS_W'(ms_inc);

    priority if (s4_short_r) begin
      out_epoch_nxt = '0;
    end else if (unit_mode) begin
      out_epoch_nxt = {{(EPOCH_W - MS_W){ms_adj[MS_W-1]}}, ms_adj};
    end else begin
      out_epoch_nxt = us_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (advance) begin
      s1_vld_r  <= q_pop;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      s4_vld_r  <= s3_vld_r;
      out_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_short_r  <= q_rdata.short_input;
      s1_year_r   <= q_rdata.fld.year;
      s1_month_r  <= q_rdata.fld.month;
      s1_day_r    <= q_rdata.fld.day;
      s1_milli_r  <= q_rdata.fld.milli;
      s1_micro_r  <= q_rdata.fld.micro;
      s1_qy_r     <= q_rdata.fld.year[13:2];
      s1_qp_r     <= year_m1[13:2];
      s1_cy_r     <= s1_cy_nxt;
      s1_cp_r     <= s1_cp_nxt;
      s1_hms_r    <= s1_hms_nxt;

      s2_short_r  <= s1_short_r;
      s2_days_r   <= s2_days_nxt;
      s2_hms_r    <= s1_hms_r;
      s2_milli_r  <= s1_milli_r;
      s2_micro_r  <= s1_micro_r;

      s3_short_r  <= s2_short_r;
      s3_sec_r    <= s3_sec_nxt;
      s3_milli_r  <= s2_milli_r;
      s3_micro_r  <= s2_micro_r;

      s4_short_r  <= s3_short_r;
      s4_ms_r     <= s4_ms_nxt;
      s4_micro_r  <= s3_micro_r;

      out_short_r <= s4_short_r;
      out_epoch_r <= out_epoch_nxt;
    end
  end

endmodule

// File: test/timestamp_text_to_epoch_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the timestamp text to epoch converter: directed texts, then random.
module timestamp_text_to_epoch_test;

  localparam longint US_SECOND = 1000000;
  localparam longint US_MINUTE = 60 * US_SECOND;
  localparam longint US_HOUR = 60 * US_MINUTE;
  localparam longint US_DAY = 24 * US_HOUR;
  localparam int BASE_YEAR = 1970;
  localparam int LAST_POS = 63;
  localparam int RANDOM_CHARS = 700;
  localparam byte unsigned DIGIT_LO = 8'h30;
  localparam byte unsigned DIGIT_HI = 8'h39;
  localparam logic [tte_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [tte_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef enum int {
    YEAR_F, MONTH_F, DAY_F, HOUR_F, MINUTE_F, SECOND_F, MILLI_F, MICRO_F
  } field_e;

  typedef struct packed {
    logic [tte_pkg::EPOCH_W-1:0] count;
    logic                        short_text;
  } epoch_word_t;

  typedef struct {
    string  text;
    bit     basic;
    bit     millis;
    bit     known;
    longint count;
    bit     short_text;
  } probe_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [tte_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [tte_pkg::CFG_DATA_W-1:0] cfg_wdata;

  tte_in_if in_chan ();
  tte_out_if out_chan ();

  timestamp_text_to_epoch uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state, mirrors the parser
  bit          mode_basic = 1'b0;
  bit          mode_millis = 1'b0;
  int unsigned text_pos = 0;
  int unsigned fval [8] = '{default: 0};
  bit          field_done = 1'b0;

  epoch_word_t  awaited [$];
  byte unsigned stamp [$];
  int           mismatches = 0;
  bit           gaps_on = 1'b1;
  int           random_sent = 0;

  probe_t probes [$] = '{
    '{"1970-01-01T00:00:00.000000", 0, 0, 1, 0, 0},
    '{"1970-01-00T00:00:00.000000", 0, 0, 1, -64'sd86400000000, 0},
    '{"0000-00-00T00:00:00.000000", 0, 0, 1, -64'sd86400000000, 0},
    '{"1", 0, 0, 1, 0, 1},
    '{"2024-06-15T12:30:45.12", 0, 0, 1, 0, 1},
    '{"2024-06-15T12:30:45.123", 0, 0, 0, 0, 0},
    '{"2024-02-29T23:59:59.999999", 0, 0, 0, 0, 0},
    '{"9999-99-99T99:99:99.999999", 0, 0, 0, 0, 0},
    '{"1969-12-31T23:59:59.999999", 0, 0, 0, 0, 0},
    '{"2000-13-01T00:00:00.000000", 0, 0, 0, 0, 0},
    '{"2023-1x-05T 1:+2:-3.4 5 6", 0, 0, 0, 0, 0},
    '{"2024-06-15T12:30:45.123456Z and a long tail that runs past the last position",
      0, 0, 0, 0, 0},
    '{"1970-01-01T00:00:00.000999", 0, 1, 1, 0, 0},
    '{"1970-01-00T00:00:00.000999", 0, 1, 1, -64'sd86399999, 0},
    '{"2038-01-19T03:14:07.999999", 0, 1, 0, 0, 0},
    '{"19700101T000000.000000", 1, 0, 1, 0, 0},
    '{"19700101T000000.00", 1, 0, 1, 0, 1},
    '{"19700101T000000.000", 1, 0, 1, 0, 0},
    '{"99999999T999999.999999", 1, 0, 0, 0, 0},
    '{"2024-06-15T12:30:45.123456", 1, 0, 0, 0, 0},
    '{"20240229T235959.999999", 1, 1, 0, 0, 0},
    '{"19691231T235959.999999", 1, 1, 0, 0, 0}
  };

  function automatic int field_first(bit basic, int f);
    case (f)
      YEAR_F:   return 0;
      MONTH_F:  return basic ? 4 : 5;
      DAY_F:    return basic ? 6 : 8;
      HOUR_F:   return basic ? 9 : 11;
      MINUTE_F: return basic ? 11 : 14;
      SECOND_F: return basic ? 13 : 17;
      MILLI_F:  return basic ? 16 : 20;
      default:  return basic ? 19 : 23;
    endcase
  endfunction

  function automatic int field_len(int f);
    return (f == YEAR_F) ? 4 : (f >= MILLI_F) ? 3 : 2;
  endfunction

  function automatic int unsigned field_mask(int f);
    return (f == YEAR_F) ? 'h3FFF : (f >= MILLI_F) ? 'h3FF : 'h7F;
  endfunction

  function automatic longint leaps_through(longint y);
    return y / 4 - y / 100 + y / 400;
  endfunction

  // days in the months before month m, non-leap, for m of 2 to 13
  function automatic longint days_ahead(int unsigned m);
    case (m)
      2:       return 31;
      3:       return 59;
      4:       return 90;
      5:       return 120;
      6:       return 151;
      7:       return 181;
      8:       return 212;
      9:       return 243;
      10:      return 273;
      11:      return 304;
      12:      return 334;
      default: return 365;
    endcase
  endfunction

  function automatic longint micros_since_epoch();
    longint e;
    longint days;
    longint y;
    longint leap;
    int unsigned m;
    y = longint'(fval[YEAR_F]);
    m = fval[MONTH_F];
    leap = ((y % 400 == 0) || (y % 100 != 0 && y % 4 == 0)) ? 1 : 0;
    days = 0;
    e = longint'(fval[MICRO_F]) + longint'(fval[MILLI_F]) * 1000
      + longint'(fval[SECOND_F]) * US_SECOND + longint'(fval[MINUTE_F]) * US_MINUTE
      + longint'(fval[HOUR_F]) * US_HOUR + (longint'(fval[DAY_F]) - 1) * US_DAY;
    if (m >= 2) begin
      // months past December each count 31 days
      days = (m <= 13) ? days_ahead(m) : 365 + (longint'(m) - 13) * 31;
      if (m > 2) days += leap;
    end
    if (y > BASE_YEAR)
      days += 365 * (y - BASE_YEAR) + leaps_through(y - 1) - leaps_through(BASE_YEAR - 1);
    return e + days * US_DAY;
  endfunction

  // advance the predictor by one accepted character; 1 when it yields a word
  function automatic bit take_char(byte unsigned c, bit fin, output epoch_word_t word);
    int unsigned p;
    int s;
    longint e;
    p = text_pos;
    word = '0;
    for (int f = 0; f < 8; f++) begin
      s = field_first(mode_basic, f);
      if (p >= s && p < s + field_len(f)) begin
        if (p == s) field_done = 1'b0;
        if (c >= DIGIT_LO && c <= DIGIT_HI && !field_done)
          fval[f] = (fval[f] * 10 + (c - DIGIT_LO)) & field_mask(f);
        else
          field_done = 1'b1;
      end
    end
    if (!fin) begin
      text_pos = (p < LAST_POS) ? p + 1 : LAST_POS;
      return 1'b0;
    end
    if (p + 1 < field_first(mode_basic, MICRO_F)) begin
      word.short_text = 1'b1;
    end else begin
      e = micros_since_epoch();
      if (mode_millis) e = e / 1000;
      word.count = e[tte_pkg::EPOCH_W-1:0];
    end
    text_pos = 0;
    fval = '{default: 0};
    field_done = 1'b0;
    return 1'b1;
  endfunction

  function automatic int roll(int lo, int hi, int wide);
    return ($urandom_range(0, 4) == 0) ? $urandom_range(0, wide) : $urandom_range(lo, hi);
  endfunction

  task automatic send_text(bit known, epoch_word_t typed);
    epoch_word_t word;
    for (int k = 0; k < stamp.size(); k++) begin
      if (gaps_on && $urandom_range(0, 3) == 0) begin
        in_chan.valid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      in_chan.valid <= 1'b1;
      in_chan.text_char <= stamp[k];
      in_chan.is_final <= (k == stamp.size() - 1);
      do @(posedge clk); while (!in_chan.ready);
      if (take_char(stamp[k], k == stamp.size() - 1, word))
        awaited.push_back(known ? typed : word);
    end
  endtask

  // drain, then write both registers; spare indexes get the opposite values
  task automatic set_mode(bit basic, bit millis);
    in_chan.valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= tte_pkg::CFG_LAYOUT;
    cfg_wdata <= basic;
    @(posedge clk);
    mode_basic = basic;
    cfg_index <= tte_pkg::CFG_UNIT;
    cfg_wdata <= millis;
    @(posedge clk);
    mode_millis = millis;
    cfg_index <= CFG_SPARE_A;
    cfg_wdata <= !basic;
    @(posedge clk);
    cfg_index <= CFG_SPARE_B;
    cfg_wdata <= !millis;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic compose_text();
    string s;
    int kind;
    int n;
    int year, month, day, hour, minute, second;
    kind = $urandom_range(0, 9);
    stamp.delete();
    if (kind == 0) begin
      // noise: digits mixed with any byte
      n = $urandom_range(1, 70);
      repeat (n)
        stamp.push_back($urandom_range(0, 1) ? 8'(DIGIT_LO + $urandom_range(0, 9))
                                              : 8'($urandom_range(0, 255)));
      return;
    end
    year = ($urandom_range(0, 5) == 0) ? $urandom_range(1900, 1969) : roll(1970, 2100, 9999);
    month = roll(1, 12, 99);
    day = roll(1, 31, 99);
    hour = roll(0, 23, 99);
    minute = roll(0, 59, 99);
    second = roll(0, 59, 99);
    if (mode_basic)
      s = $sformatf("%04d%02d%02dT%02d%02d%02d.%03d%03d", year, month, day, hour, minute,
                    second, $urandom_range(0, 999), $urandom_range(0, 999));
    else
      s = $sformatf("%04d-%02d-%02dT%02d:%02d:%02d.%03d%03d", year, month, day, hour, minute,
                    second, $urandom_range(0, 999), $urandom_range(0, 999));
    for (int k = 0; k < s.len(); k++) stamp.push_back(s[k]);
    case (kind)
      1: begin
        n = $urandom_range(1, stamp.size());
        stamp = stamp[0:n-1];
      end
      2: repeat ($urandom_range(1, 3))
        stamp[$urandom_range(0, stamp.size() - 1)] = 8'($urandom_range(0, 255));
      3: repeat ($urandom_range(1, 45)) stamp.push_back(8'($urandom_range(0, 255)));
      default: ;
    endcase
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : result_sink
    int hold;
    epoch_word_t want;
    hold = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_chan.valid && out_chan.ready) begin
        if (awaited.size() == 0) begin
          $error("unexpected word: epoch_count %0d, short_input %0b",
                 out_chan.epoch_count, out_chan.short_input);
          mismatches++;
        end else begin
          want = awaited.pop_front();
          if (out_chan.epoch_count !== want.count) begin
            $error("epoch_count: expected %0d, got %0d", $signed(want.count),
                   out_chan.epoch_count);
            mismatches++;
          end
          if (out_chan.short_input !== want.short_text) begin
            $error("short_input: expected %0b, got %0b", want.short_text,
                   out_chan.short_input);
            mismatches++;
          end
        end
      end
      if (hold > 0) begin
        hold--;
        out_chan.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        hold = $urandom_range(0, 6);
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    epoch_word_t typed;
    int texts_left;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = tte_pkg::CFG_LAYOUT;
    cfg_wdata = '0;
    in_chan.valid = 1'b0;
    in_chan.text_char = '0;
    in_chan.is_final = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < probes.size(); i++) begin
      if (probes[i].basic != mode_basic || probes[i].millis != mode_millis)
        set_mode(probes[i].basic, probes[i].millis);
      stamp.delete();
      for (int k = 0; k < probes[i].text.len(); k++) stamp.push_back(probes[i].text[k]);
      typed.count = probes[i].count[tte_pkg::EPOCH_W-1:0];
      typed.short_text = probes[i].short_text;
      send_text(probes[i].known, typed);
    end

    typed = '0;
    while (random_sent < RANDOM_CHARS) begin
      set_mode($urandom_range(0, 1), $urandom_range(0, 1));
      // hold both sides steady through the last quarter
      gaps_on = (random_sent < RANDOM_CHARS * 3 / 4) && ($urandom_range(0, 3) != 0);
      texts_left = $urandom_range(4, 12);
      while (texts_left > 0 && random_sent < RANDOM_CHARS) begin
        compose_text();
        send_text(1'b0, typed);
        random_sent += stamp.size();
        texts_left--;
      end
    end

    in_chan.valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
